>>> design/hsvrgb_pkg.sv
// Shared types and constants for the integer HSV to RGB converter.
package hsvrgb_pkg;

  localparam int ChWidth  = 8;
  localparam int HueCodes = 1 << ChWidth;
  localparam int DegFull   = 360;
  localparam int DegSector = 60;
  localparam int DegWrap   = 65536;
  localparam int RemScale  = 4;
  localparam int RemWrap   = 256;
  localparam logic [ChWidth-1:0] CH_MAX = 8'd255;

  typedef logic [ChWidth-1:0] chan_t;

  // Hue sectors of the color wheel, in the order of the six-way select
  typedef enum logic [2:0] {
    SEC_RED_YEL,
    SEC_YEL_GRN,
    SEC_GRN_CYN,
    SEC_CYN_BLU,
    SEC_BLU_MAG,
    SEC_MAG_RED
  } sector_t;

endpackage

>>> design/hsv_to_rgb_integer.sv
// Pipelined 8-bit integer HSV to RGB converter.
//
// Accepts one transaction per clock: start with hue_in, sat_in and value_in is
// taken at every edge, since busy is held low. Each result appears on red_out,
// green_out and blue_out for exactly one cycle with done high. The receiver
// cannot stall the pipe, and none is needed: nothing inside waits on the
// output. Four register stages make up the pipe: a hue table lookup (built
// at elaboration from HUE_MAX), the saturation products, the value products,
// and the channel select. Zero saturation gives grey with every channel equal
// to value_in. No state besides the pipeline registers; reset clears only the
// valid bits.
module hsv_to_rgb_integer
  import hsvrgb_pkg::*;
#(
  parameter int HUE_MAX = 254
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] hue_in,
  input  logic [7:0] sat_in,
  input  logic [7:0] value_in,
  output logic       done,
  output logic [7:0] red_out,
  output logic [7:0] green_out,
  output logic [7:0] blue_out
);

  // Hue tables: sector and in-sector remainder for every hue code
  sector_t sec_lut [HueCodes];
  chan_t   rem_lut [HueCodes];

  for (genvar i = 0; i < HueCodes; i++) begin : g_hue_lut
    localparam int Deg = ((i * DegFull) / HUE_MAX) % DegWrap;
    localparam int Sec = (Deg < DegFull) ? (Deg / DegSector) : 0;
    localparam int Rem = ((Deg - Sec * DegSector) * RemScale) % RemWrap;
    assign sec_lut[i] = sector_t'(3'(Sec));
    assign rem_lut[i] = chan_t'(Rem);
  end

  // Pipeline valid bits
  logic v1, v2, v3, v4;

  // Stage 1: table lookup
  sector_t s1_sec;
  chan_t   s1_rem, s1_sat, s1_val;
  logic    s1_grey;

  // Stage 2: saturation terms, as multipliers of value
  sector_t s2_sec;
  chan_t   s2_mp, s2_mq, s2_mt, s2_val;
  logic    s2_grey;

  // Stage 3: p, q, t
  sector_t s3_sec;
  chan_t   s3_p, s3_q, s3_t, s3_val;
  logic    s3_grey;

  // Stage 4: output registers
  chan_t red, green, blue;

  logic [15:0] sq_prod, st_prod;
  logic [15:0] p_prod, q_prod, t_prod;
  chan_t       rem_inv;
  chan_t       red_next, green_next, blue_next;

  assign rem_inv = CH_MAX - s1_rem;
  assign sq_prod = 16'(s1_sat) * 16'(s1_rem);
  assign st_prod = 16'(s1_sat) * 16'(rem_inv);

  assign p_prod = 16'(s2_val) * 16'(s2_mp);
  assign q_prod = 16'(s2_val) * 16'(s2_mq);
  assign t_prod = 16'(s2_val) * 16'(s2_mt);

  // Route value, p, q and t to the channels by sector; grey forces all to value
  always_comb begin
    case (s3_sec)
      SEC_RED_YEL: begin
        red_next = s3_val; green_next = s3_t;   blue_next = s3_p;
      end
      SEC_YEL_GRN: begin
        red_next = s3_q;   green_next = s3_val; blue_next = s3_p;
      end
      SEC_GRN_CYN: begin
        red_next = s3_p;   green_next = s3_val; blue_next = s3_t;
      end
      SEC_CYN_BLU: begin
        red_next = s3_p;   green_next = s3_q;   blue_next = s3_val;
      end
      SEC_BLU_MAG: begin
        red_next = s3_t;   green_next = s3_p;   blue_next = s3_val;
      end
      default: begin
        red_next = s3_val; green_next = s3_p;   blue_next = s3_q;
      end
    endcase
    if (s3_grey) begin
      red_next   = s3_val;
      green_next = s3_val;
      blue_next  = s3_val;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start & ~busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    s1_sec  <= sec_lut[hue_in];
    s1_rem  <= rem_lut[hue_in];
    s1_sat  <= sat_in;
    s1_val  <= value_in;
    s1_grey <= (sat_in == '0);

    s2_sec  <= s1_sec;
    s2_mp   <= CH_MAX - s1_sat;
    s2_mq   <= CH_MAX - sq_prod[15:8];
    s2_mt   <= CH_MAX - st_prod[15:8];
    s2_val  <= s1_val;
    s2_grey <= s1_grey;

    s3_sec  <= s2_sec;
    s3_p    <= p_prod[15:8];
    s3_q    <= q_prod[15:8];
    s3_t    <= t_prod[15:8];
    s3_val  <= s2_val;
    s3_grey <= s2_grey;

    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

  assign busy      = 1'b0;
  assign done      = v4;
  assign red_out   = red;
  assign green_out = green;
  assign blue_out  = blue;

endmodule
